// ----- rtl/core/fire_effect_pixel_spread_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fire effect pixel spread block.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FIRE_EFFECT_PIXEL_SPREAD_ASSERT_SVH
`define FIRE_EFFECT_PIXEL_SPREAD_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define FEP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define FEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fep_pkg.sv -----
// ----------------------------------------------------------------------------
// fep_pkg
// Shared constants, register codes and helpers of the fire effect block.
// ----------------------------------------------------------------------------
package fep_pkg;

	// Screen geometry and pixel store size.
	localparam int unsigned SCREEN_W = 640;
	localparam int unsigned SCREEN_H = 360;
	localparam int unsigned PIXELS   = SCREEN_W * SCREEN_H;
	localparam int unsigned PIX_AW   = $clog2(PIXELS);

	// Field widths of the item and result beats.
	localparam int unsigned IDX_W   = 18;
	localparam int unsigned INT_W   = 8;
	localparam int unsigned COLOR_W = 32;
	// Width for index range checks, wider than the item index field.
	localparam int unsigned CMP_W   = 26;

	// Register reset values.
	localparam logic [INT_W-1:0] PAL_RED_RST   = 8'd255;
	localparam logic [INT_W-1:0] PAL_GREEN_RST = 8'd128;
	localparam logic [INT_W-1:0] PAL_BLUE_RST  = 8'd0;
	localparam logic [INT_W-1:0] DECAY_RST     = 8'd2;

	// Register index codes (byte address bits 3:2).
	typedef enum logic [1:0] {
		REG_PAL_RED   = 2'd0,
		REG_PAL_GREEN = 2'd1,
		REG_PAL_BLUE  = 2'd2,
		REG_DECAY     = 2'd3
	} reg_idx_t;

	// Item kinds.
	localparam logic KIND_SET    = 1'b0;
	localparam logic KIND_SPREAD = 1'b1;

	// Exact floor(x / 255) for any 16-bit x whose quotient fits in a byte.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = 17'(x) + 17'(x[15:8]) + 17'd1;
		return sum[15:8];
	endfunction

endpackage

// ----- rtl/core/fep_ram.sv -----
// ----------------------------------------------------------------------------
// fep_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fep_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/fire_effect_pixel_spread.sv -----
// ----------------------------------------------------------------------------
// fire_effect_pixel_spread
// An item taken passes stage 1 (memory read), stage 2 (products) and the
// result registers that drive done. Busy holds off the next item while one
// is in stage 1, where its pixel is written on the memory's single write port.
// Reset: registers return to their defaults and a clearing pass writes zero to
// all SCREEN_W*SCREEN_H pixels, one per cycle, with busy high; results are
// never stalled by the receiver.
// ----------------------------------------------------------------------------
module fire_effect_pixel_spread (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Item beat.
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [fep_pkg::IDX_W-1:0]     pixel_index,
	input  logic [1:0]                    rand_offset,
	input  logic [fep_pkg::INT_W-1:0]     new_intensity,
	// Result beat.
	output logic                          done,
	output logic                          wrote,
	output logic [fep_pkg::IDX_W-1:0]     dest_index,
	output logic [fep_pkg::COLOR_W-1:0]   color_argb
);

	import fep_pkg::*;

	// Configuration registers.
	logic [INT_W-1:0] pal_red_q, pal_green_q, pal_blue_q, decay_q;
	logic             cfg_wr;

	// Clearing pass.
	logic              clearing_q;
	logic [PIX_AW-1:0] clr_cnt_q;

	// Decode of an incoming item.
	logic              accept;
	logic [CMP_W-1:0]  src_ext;
	logic [CMP_W-1:0]  dest_full;
	logic              in_range;
	logic              spread_ok;
	logic              item_ok;
	logic [IDX_W-1:0]  item_dst;

	// Stage 1: memory read returns.
	logic              vld_s1, kind_s1, ok_s1;
	logic [IDX_W-1:0]  dst_s1;
	logic [1:0]        r_s1;
	logic [INT_W-1:0]  new_s1;
	logic [INT_W-1:0]  rd_data;
	logic [INT_W-1:0]  decay;
	logic [INT_W-1:0]  v;
	logic [8:0]        twov;
	logic              lower;
	logic [INT_W-1:0]  mult;
	logic [INT_W-1:0]  pal [3];
	logic [INT_W-1:0]  opnd [3];

	// Stage 2: products registered.
	logic              vld_s2, ok_s2, set_s2;
	logic [IDX_W-1:0]  dst_s2;
	logic [INT_W-1:0]  alpha_s2;
	logic [15:0]       prod_s2 [3];
	logic [INT_W-1:0]  base_s2 [3];
	logic [INT_W-1:0]  chan [3];

	// Memory ports.
	logic              mem_we;
	logic [PIX_AW-1:0] mem_waddr;
	logic [INT_W-1:0]  mem_wdata;

	// Result registers.
	logic               done_q, wrote_q;
	logic [IDX_W-1:0]   dest_q;
	logic [COLOR_W-1:0] color_q;

	// Register writes on the access beat.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_red_q   <= PAL_RED_RST;
			pal_green_q <= PAL_GREEN_RST;
			pal_blue_q  <= PAL_BLUE_RST;
			decay_q     <= DECAY_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_PAL_RED:   pal_red_q   <= pwdata[INT_W-1:0];
				REG_PAL_GREEN: pal_green_q <= pwdata[INT_W-1:0];
				REG_PAL_BLUE:  pal_blue_q  <= pwdata[INT_W-1:0];
				REG_DECAY:     decay_q     <= pwdata[INT_W-1:0];
				default:       pal_red_q   <= pal_red_q;
			endcase
		end
	end

	// Register read mux.
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_PAL_RED:   prdata = {24'd0, pal_red_q};
			REG_PAL_GREEN: prdata = {24'd0, pal_green_q};
			REG_PAL_BLUE:  prdata = {24'd0, pal_blue_q};
			REG_DECAY:     prdata = {24'd0, decay_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Clearing pass after reset, one pixel per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == PIX_AW'(PIXELS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + PIX_AW'(1);
		end
	end

	// An item is taken only when the clearing pass is over and no earlier item is waiting on the memory.
	assign busy   = clearing_q | vld_s1;
	assign accept = start & ~busy;

	// Range checks and destination of the incoming item.
	assign src_ext   = CMP_W'(pixel_index);
	assign in_range  = src_ext < CMP_W'(PIXELS);
	assign spread_ok = (src_ext + CMP_W'(1)) >= (CMP_W'(SCREEN_W) + CMP_W'(rand_offset));
	assign dest_full = src_ext + CMP_W'(1) - CMP_W'(SCREEN_W) - CMP_W'(rand_offset);
	assign item_ok   = in_range & ((kind == KIND_SET) | spread_ok);
	assign item_dst  = (kind == KIND_SET) ? pixel_index : dest_full[IDX_W-1:0];

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			ok_s1   <= item_ok;
			dst_s1  <= item_dst;
			r_s1    <= rand_offset;
			new_s1  <= new_intensity;
		end
	end

	// Pixel intensity memory.
	fep_ram #(
		.WIDTH (INT_W),
		.DEPTH (PIXELS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (PIX_AW'(pixel_index)),
		.rdata (rd_data)
	);

	// Decay and ramp operands from the source intensity.
	assign decay = (r_s1 != 2'd0) ? decay_q : '0;
	assign v     = (rd_data > decay) ? (rd_data - decay) : '0;
	assign twov  = {v, 1'b0};
	assign lower = twov < 9'd255;
	assign mult  = lower ? twov[7:0] : 8'(twov - 9'd255);
	assign pal[0] = pal_red_q;
	assign pal[1] = pal_green_q;
	assign pal[2] = pal_blue_q;

	// Lower segment scales the mid point, upper segment scales its distance to full.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			opnd[c] = lower ? pal[c] : ~pal[c];
		end
	end

	// Write back: clearing pass, a set value, or the decayed spread value.
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = vld_s1 & ok_s1;
			mem_waddr = PIX_AW'(dst_s1);
			mem_wdata = (kind_s1 == KIND_SET) ? new_s1 : v;
		end
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2 payload: one product per color channel.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ok_s2    <= ok_s1;
			set_s2   <= (kind_s1 == KIND_SET);
			dst_s2   <= dst_s1;
			alpha_s2 <= (kind_s1 == KIND_SET) ? new_s1 : v;
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= 16'(opnd[c]) * 16'(mult);
				base_s2[c] <= lower ? '0 : pal[c];
			end
		end
	end

	// Channel values from the scaled products; a set item gives zero channels.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan[c] = set_s2 ? '0 : (base_s2[c] + div255(prod_s2[c]));
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
		end
	end

	// Result payload; a skipped item reports all zero.
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			wrote_q <= ok_s2;
			dest_q  <= ok_s2 ? dst_s2 : '0;
			color_q <= ok_s2 ? {alpha_s2, chan[0], chan[1], chan[2]} : '0;
		end
	end

	assign done       = done_q;
	assign wrote      = wrote_q;
	assign dest_index = dest_q;
	assign color_argb = color_q;

endmodule

// ----- rtl/core/fep_checker.sv -----
// ----------------------------------------------------------------------------
// fep_checker
// Port-level checks of item and result timing, and of skipped result payload, for the fire effect block.
// ----------------------------------------------------------------------------
`include "fire_effect_pixel_spread_assert.svh"

module fep_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        wrote,
	input logic [fep_pkg::IDX_W-1:0]   dest_index,
	input logic [fep_pkg::COLOR_W-1:0] color_argb
);

	import fep_pkg::*;

	// Every result beat comes from a taken item that has passed stage 1, stage 2 and the result registers.
	`FEP_ASSERT_IMPLIES(a_done_has_item, clk, arst_n, done, $past(start && !busy, 3), "result beat without an item")

	// Every taken item yields its result beat once it has passed stage 1, stage 2 and the result registers.
	`FEP_ASSERT_IMPLIES(a_item_has_done, clk, arst_n, $past(start && !busy, 3), done, "item without a result beat")

	// The block holds off the next item for the cycle after a take.
	`FEP_ASSERT_NEXT(a_busy_after_take, clk, arst_n, start && !busy, busy, "busy low after an item")

	// A result that wrote nothing carries all-zero payload.
	`FEP_ASSERT_IMPLIES(a_skip_zero, clk, arst_n, done && !wrote, (dest_index == '0) && (color_argb == '0), "skipped result not zero")

endmodule

bind fire_effect_pixel_spread fep_checker u_fep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.wrote      (wrote),
	.dest_index (dest_index),
	.color_argb (color_argb)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect pixel spread testbench
// Drives set and spread beats into the block, keeps its own copy of the
// intensity store and palette registers, and checks every result beat
// field by field against the predicted pixel write, in order.
// ----------------------------------------------------------------------------
module testbench;
	import fep_pkg::*;

	// Idle cycles with no accepted item and no result beat before the run is declared hung.
	// The limit must outlast the clearing pass after reset over all SCREEN_W*SCREEN_H pixels.
	localparam int unsigned HANG_LIMIT = 1000000;
	localparam int unsigned IDX_SPAN   = 1 << IDX_W;

	typedef struct packed {
		logic               wrote;
		logic [IDX_W-1:0]   dest;
		logic [COLOR_W-1:0] color;
	} pixel_write_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic               kind;
	logic [IDX_W-1:0]   pixel_index;
	logic [1:0]         rand_offset;
	logic [INT_W-1:0]   new_intensity;
	logic               done;
	logic               wrote;
	logic [IDX_W-1:0]   dest_index;
	logic [COLOR_W-1:0] color_argb;

	// Mirror of the block's state and registers.
	logic [INT_W-1:0] heat_map [PIXELS];
	logic [INT_W-1:0] mid_red;
	logic [INT_W-1:0] mid_green;
	logic [INT_W-1:0] mid_blue;
	logic [INT_W-1:0] fade_step;

	pixel_write_t pending_writes[$];
	int           fail_count = 0;
	int           items_sent = 0;
	int unsigned  idle_cycles = 0;
	logic         gaps_on = 1'b1;

	fire_effect_pixel_spread u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.pixel_index   (pixel_index),
		.rand_offset   (rand_offset),
		.new_intensity (new_intensity),
		.done          (done),
		.wrote         (wrote),
		.dest_index    (dest_index),
		.color_argb    (color_argb)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One channel of the two-segment palette ramp, black to mid point to white.
	function automatic logic [7:0] palette_level(input int unsigned mid, input int unsigned v);
		int unsigned level;
		if (2 * v < 255) begin
			level = (mid * 2 * v) / 255;
		end else begin
			level = mid + ((255 - mid) * (2 * v - 255)) / 255;
		end
		return level[7:0];
	endfunction

	// Applies one item to the mirrored store and returns the pixel write it causes.
	function automatic pixel_write_t predict_pixel_write(input logic k,
			input logic [IDX_W-1:0] idx, input logic [1:0] r, input logic [INT_W-1:0] level);
		pixel_write_t res;
		int unsigned  src;
		int unsigned  dst;
		int unsigned  heat;
		int unsigned  loss;
		int unsigned  v;
		res = '0;
		src = idx;
		if (src >= PIXELS) begin
			return res;
		end
		if (k == KIND_SET) begin
			heat_map[src] = level;
			res.wrote = 1'b1;
			res.dest  = idx;
			res.color = {level, 24'd0};
			return res;
		end
		// A spread whose destination lies above the top row is skipped.
		if (src + 1 < SCREEN_W + r) begin
			return res;
		end
		dst  = src + 1 - SCREEN_W - r;
		heat = heat_map[src];
		loss = (r != 2'd0) ? fade_step : 0;
		res.wrote = 1'b1;
		res.dest  = dst[IDX_W-1:0];
		if (heat <= loss) begin
			heat_map[dst] = '0;
		end else begin
			v = heat - loss;
			heat_map[dst] = v[7:0];
			res.color = {v[7:0], palette_level(mid_red, v), palette_level(mid_green, v),
				palette_level(mid_blue, v)};
		end
		return res;
	endfunction

	// Sends one item beat, with an optional random gap before it.
	task automatic send_item(input logic k, input logic [IDX_W-1:0] idx, input logic [1:0] r,
			input logic [INT_W-1:0] level);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start         <= 1'b1;
		kind          <= k;
		pixel_index   <= idx;
		rand_offset   <= r;
		new_intensity <= level;
		do @(posedge clk); while (busy !== 1'b0);
		pending_writes.push_back(predict_pixel_write(k, idx, r, level));
		items_sent++;
	endtask

	// Stops sending and waits until every expected result beat has come.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Two-phase register write; upper data bits carry noise the block must drop.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_PAL_RED:   mid_red   = value;
			REG_PAL_GREEN: mid_green = value;
			REG_PAL_BLUE:  mid_blue  = value;
			REG_DECAY:     fade_step = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_palette(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue, input logic [7:0] step);
		wait_idle();
		write_reg(REG_PAL_RED, red);
		write_reg(REG_PAL_GREEN, green);
		write_reg(REG_PAL_BLUE, blue);
		write_reg(REG_DECAY, step);
	endtask

	// Mostly set-then-spread chains that climb the screen, plus scattered noise.
	task automatic random_items(input int count);
		int          stop_at;
		int unsigned src;
		int unsigned hops;
		int unsigned top;
		logic [1:0]  r;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3 * SCREEN_W) :
						$urandom_range(SCREEN_W, PIXELS - 1);
					top = (fade_step + 2 > 255) ? 255 : fade_step + 2;
					send_item(KIND_SET, src[IDX_W-1:0], 2'($urandom),
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, top)) : 8'($urandom));
					hops = $urandom_range(1, 4);
					while (hops != 0) begin
						r = 2'($urandom);
						send_item(KIND_SPREAD, src[IDX_W-1:0], r, 8'($urandom));
						if (src + 1 < SCREEN_W + r) begin
							break;
						end
						src  = src + 1 - SCREEN_W - r;
						hops = hops - 1;
					end
				end
				6: send_item(KIND_SET, IDX_W'($urandom_range(0, IDX_SPAN - 1)), 2'($urandom),
					8'($urandom));
				7: send_item(KIND_SPREAD, IDX_W'($urandom_range(0, IDX_SPAN - 1)), 2'($urandom),
					8'($urandom));
				8: send_item(KIND_SPREAD, IDX_W'($urandom_range(0, SCREEN_W + 3)), 2'($urandom),
					8'($urandom));
				default: send_item(1'($urandom), IDX_W'($urandom_range(PIXELS - 2, PIXELS + 2)),
					2'($urandom), 8'($urandom));
			endcase
		end
	endtask

	// Set beats at the index extremes and beyond the screen.
	task automatic test_set_items();
		send_item(KIND_SET, '0, 2'd3, 8'd255);
		send_item(KIND_SET, IDX_W'(PIXELS - 1), 2'd0, 8'h80);
		send_item(KIND_SET, IDX_W'(PIXELS), 2'd1, 8'h55);
		send_item(KIND_SET, '1, 2'd2, 8'hAA);
		send_item(KIND_SET, '0, 2'd0, 8'd0);
	endtask

	// Spread beats: each decay case, the ramp knee and the top row edge.
	task automatic test_spread_items();
		// No decay with a zero offset.
		send_item(KIND_SET, 18'd1000, 2'd0, 8'd200);
		send_item(KIND_SPREAD, 18'd1000, 2'd0, 8'd0);
		// Intensity equal to the decay clears the destination.
		send_item(KIND_SET, 18'd700, 2'd0, 8'd2);
		send_item(KIND_SPREAD, 18'd700, 2'd1, 8'd0);
		// Spread from a pixel never written.
		send_item(KIND_SPREAD, 18'd5000, 2'd3, 8'd0);
		// Last value below the ramp knee, first above it, and full scale.
		send_item(KIND_SET, 18'd2000, 2'd0, 8'd127);
		send_item(KIND_SPREAD, 18'd2000, 2'd0, 8'd0);
		send_item(KIND_SET, 18'd3000, 2'd0, 8'd130);
		send_item(KIND_SPREAD, 18'd3000, 2'd1, 8'd0);
		send_item(KIND_SET, 18'd4000, 2'd0, 8'd255);
		send_item(KIND_SPREAD, 18'd4000, 2'd0, 8'd0);
		send_item(KIND_SET, 18'd4001, 2'd0, 8'd1);
		send_item(KIND_SPREAD, 18'd4001, 2'd0, 8'd0);
		// Destination exactly at pixel zero, and one step past the top row.
		send_item(KIND_SET, 18'd639, 2'd0, 8'd50);
		send_item(KIND_SPREAD, 18'd639, 2'd0, 8'd0);
		send_item(KIND_SPREAD, 18'd639, 2'd1, 8'd0);
		send_item(KIND_SET, 18'd642, 2'd0, 8'd90);
		send_item(KIND_SPREAD, 18'd642, 2'd3, 8'd0);
		send_item(KIND_SPREAD, 18'd641, 2'd3, 8'd0);
		// Source beyond the screen.
		send_item(KIND_SPREAD, IDX_W'(PIXELS), 2'd0, 8'd0);
		send_item(KIND_SPREAD, '1, 2'd3, 8'hFF);
	endtask

	task automatic test_default_palette();
		random_items(300);
	endtask

	task automatic test_zero_registers();
		write_palette(8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_SET, 18'd9000, 2'd0, 8'd40);
		send_item(KIND_SPREAD, 18'd9000, 2'd2, 8'd0);
		random_items(200);
	endtask

	task automatic test_full_registers();
		write_palette(8'd255, 8'd255, 8'd255, 8'd255);
		send_item(KIND_SET, 18'd9100, 2'd0, 8'd255);
		send_item(KIND_SPREAD, 18'd9100, 2'd1, 8'd0);
		send_item(KIND_SPREAD, 18'd9100, 2'd0, 8'd0);
		random_items(200);
	endtask

	task automatic test_random_registers();
		repeat (2) begin
			write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)));
			random_items(150);
		end
	endtask

	// Closing stretch with the sender never pausing.
	task automatic test_back_to_back();
		write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)));
		gaps_on = 1'b0;
		random_items(150);
	endtask

	// Compares each result beat with the oldest predicted pixel write.
	always @(posedge clk) begin : check_results
		pixel_write_t exp_w;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_writes.size() == 0) begin
				$error("result beat with no item pending");
				fail_count++;
			end else begin
				exp_w = pending_writes.pop_front();
				if (wrote !== exp_w.wrote) begin
					$error("wrote: expected %0d, got %0d", exp_w.wrote, wrote);
					fail_count++;
				end
				if (dest_index !== exp_w.dest) begin
					$error("dest_index: expected %0d, got %0d", exp_w.dest, dest_index);
					fail_count++;
				end
				if (color_argb !== exp_w.color) begin
					$error("color_argb: expected %h, got %h", exp_w.color, color_argb);
					fail_count++;
				end
			end
		end
	end

	// Hang detector: counts cycles with neither an item nor a result beat.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("FAIL fire_effect_pixel_spread");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		start         = 1'b0;
		kind          = KIND_SET;
		pixel_index   = '0;
		rand_offset   = '0;
		new_intensity = '0;
		foreach (heat_map[i]) heat_map[i] = '0;
		mid_red   = PAL_RED_RST;
		mid_green = PAL_GREEN_RST;
		mid_blue  = PAL_BLUE_RST;
		fade_step = DECAY_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_set_items();
		test_spread_items();
		test_default_palette();
		test_zero_registers();
		test_full_registers();
		test_random_registers();
		test_back_to_back();
		wait_idle();

		if (fail_count == 0) begin
			$display("PASS fire_effect_pixel_spread");
		end else begin
			$display("FAIL fire_effect_pixel_spread");
		end
		$finish;
	end

endmodule

// ----- fire_effect_pixel_spread.f -----
+incdir+rtl/core
rtl/core/fep_pkg.sv
rtl/core/fep_ram.sv
rtl/core/fire_effect_pixel_spread.sv
rtl/core/fep_checker.sv
test/testbench.sv
